FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge outside reset
`define RMB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked during reset as well
`define RMB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: hw/rtl/rmb_pkg.sv
// ----------------------------------------------------------------------------
// rmb_pkg
// shared types and constants of the robust median barycenter
// ----------------------------------------------------------------------------
package rmb_pkg;
   localparam int unsigned FactorBits = 4;
   localparam logic [FactorBits-1:0] FactorReset = 4'd4;

   // what the rank unit is asked to select over
   typedef enum logic [1:0] {
      SRC_X = 2'd0,
      SRC_Y = 2'd1,
      SRC_Z = 2'd2,
      SRC_D = 2'd3
   } src_type;
endpackage

FILE: hw/rtl/rmb_req_if.sv
// ----------------------------------------------------------------------------
// rmb_req_if
// keypoint word channel
// ----------------------------------------------------------------------------
interface rmb_req_if #(parameter int COORD_BITS = 20);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] joint_x;
   logic signed [COORD_BITS-1:0] joint_y;
   logic signed [COORD_BITS-1:0] joint_z;
   logic                         joint_valid;
   logic                         last_joint;
   modport source (output valid, joint_x, joint_y, joint_z, joint_valid, last_joint,
                   input ready);
   modport sink (input valid, joint_x, joint_y, joint_z, joint_valid, last_joint,
                 output ready);
endinterface

FILE: hw/rtl/rmb_rsp_if.sv
// ----------------------------------------------------------------------------
// rmb_rsp_if
// barycenter word channel
// ----------------------------------------------------------------------------
interface rmb_rsp_if #(parameter int COORD_BITS = 20);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic signed [COORD_BITS-1:0] center_z;
   logic                         no_valid_points;
   modport source (output valid, center_x, center_y, center_z, no_valid_points,
                   input ready);
   modport sink (input valid, center_x, center_y, center_z, no_valid_points,
                 output ready);
endinterface

FILE: hw/rtl/robust_median_barycenter.sv
// after the last keypoint the medians are searched over the stored points; with no valid
// point the result is loaded from the S_NONE state without a search
// throughput: other keypoints one a cycle; after the last one input waits until the result
// is loaded, and the result stage holds while the previous word is still waiting
// reset: synchronous, active high; count, mask, factor and result valid return to default,
// point and distance memories are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// robust_median_barycenter
// median centroid of one person's keypoints with outlier rejection
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module robust_median_barycenter #(
   parameter int MAX_POINTS = 32,
   parameter int COORD_BITS = 20
) (
   input logic clock,
   input logic reset,
   rmb_req_if.sink   req,
   rmb_rsp_if.source rsp,
   input logic                            csr_we,
   input logic [rmb_pkg::FactorBits-1:0]  csr_wdata
);
   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = 2 * (COORD_BITS + 1) + 2;   // squared distance width
   localparam int VW = DW;                         // rank value width (signed)

   typedef enum logic [10:0] {
      S_LOAD  = 11'b00000000001,
      S_CRD   = 11'b00000000010,   // candidate address out
      S_CCAP  = 11'b00000000100,   // candidate value captured, scan address 0 out
      S_SEL   = 11'b00000001000,   // inner scan, one element a cycle
      S_DA    = 11'b00000010000,   // distance: read point
      S_DM    = 11'b00000100000,   // distance: one axis square a cycle
      S_LIM   = 11'b00001000000,   // limit = factor * median distance
      S_KEEP  = 11'b00010000000,   // kept-mask sweep
      S_KRD   = 11'b00100000000,
      S_OUT   = 11'b01000000000,
      S_NONE  = 11'b10000000000
   } state_type;

   // memories, undefined until written
   logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
   logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
   logic signed [COORD_BITS-1:0] mem_z [MAX_POINTS];
   logic        [DW-1:0]         mem_d [MAX_POINTS];

   state_type state_ff, state_in;
   logic [rmb_pkg::FactorBits-1:0] factor_ff;
   logic [CW-1:0] count_ff;
   logic [MAX_POINTS-1:0] kept_ff;
   logic [CW-1:0] kcount_ff;
   rmb_pkg::src_type src_ff;
   logic          phase2_ff;      // second round of medians over kept points
   logic [IW-1:0] i_ff, j_ff;     // outer candidate, inner scan index
   logic [CW-1:0] rank_ff;
   logic signed [VW-1:0] vi_ff;
   logic signed [COORD_BITS-1:0] mx_ff, my_ff, mz_ff;
   logic [DW-1:0] md_ff;
   logic [DW+rmb_pkg::FactorBits-1:0] lim_ff;
   logic [1:0] ax_ff;
   logic [DW-1:0] dacc_ff;
   logic signed [COORD_BITS-1:0] rdx_ff, rdy_ff, rdz_ff;
   logic [DW-1:0] rdd_ff;
   logic [IW-1:0] rd_addr;
   logic rsp_valid_ff;
   logic signed [COORD_BITS-1:0] ox_ff, oy_ff, oz_ff;
   logic onv_ff;

   wire req_fire = req.valid & req.ready;
   wire rsp_fire = rsp_valid_ff & rsp.ready;
   // result register is free when empty or being taken this cycle
   wire rsp_free = ~rsp_valid_ff | rsp_fire;
   assign req.ready = (state_ff == S_LOAD);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.center_x = ox_ff;
   assign rsp.center_y = oy_ff;
   assign rsp.center_z = oz_ff;
   assign rsp.no_valid_points = onv_ff;

   wire [IW-1:0] last_idx = IW'(count_ff - CW'(1));
   wire [CW-1:0] half_k = phase2_ff ? (kcount_ff >> 1) : (count_ff >> 1);
   wire [MAX_POINTS-1:0] sel_mask = phase2_ff ? kept_ff : {MAX_POINTS{1'b1}};

   // selected read value from the memory of the current source
   logic signed [VW-1:0] rv;
   always_comb begin
      unique case (src_ff)
         rmb_pkg::SRC_X: rv = VW'(rdx_ff);
         rmb_pkg::SRC_Y: rv = VW'(rdy_ff);
         rmb_pkg::SRC_Z: rv = VW'(rdz_ff);
         default:        rv = $signed({1'b0, rdd_ff[DW-2:0]});
      endcase
   end

   // shared multiplier: one axis delta squared per cycle
   logic signed [COORD_BITS:0] dlt;
   always_comb begin
      case (ax_ff)
         2'd0:    dlt = (COORD_BITS+1)'(rdx_ff) - (COORD_BITS+1)'(mx_ff);
         2'd1:    dlt = (COORD_BITS+1)'(rdy_ff) - (COORD_BITS+1)'(my_ff);
         default: dlt = (COORD_BITS+1)'(rdz_ff) - (COORD_BITS+1)'(mz_ff);
      endcase
   end
   logic signed [2*COORD_BITS+1:0] sq_full;
   assign sq_full = dlt * dlt;
   wire [DW-1:0] sq = DW'($unsigned(sq_full));

   // rank comparison of scanned element j against candidate i
   wire jsel = sel_mask[j_ff];
   wire isel = sel_mask[i_ff];
   wire below = (rv < vi_ff) | ((rv == vi_ff) & (j_ff < i_ff));
   wire scan_end = (j_ff == last_idx);
   wire [CW-1:0] rank_fin = rank_ff + CW'(jsel && below);
   wire found = isel && (rank_fin == half_k);

   // keep test of the distance read back in the sweep
   wire keep_now = (DW+rmb_pkg::FactorBits)'(rdd_ff) <= lim_ff;
   wire [CW-1:0] kcount_fin = kcount_ff + CW'(keep_now);

   always_ff @(posedge clock) begin
      if (req_fire && req.joint_valid && count_ff < CW'(MAX_POINTS)) begin
         mem_x[IW'(count_ff)] <= req.joint_x;
         mem_y[IW'(count_ff)] <= req.joint_y;
         mem_z[IW'(count_ff)] <= req.joint_z;
      end
      if (state_ff == S_DM && ax_ff == 2'd2) mem_d[i_ff] <= dacc_ff + sq;
      rdx_ff <= mem_x[rd_addr];
      rdy_ff <= mem_y[rd_addr];
      rdz_ff <= mem_z[rd_addr];
      rdd_ff <= mem_d[rd_addr];
   end

   // read address: candidate, first scan element, or the one after the current
   always_comb begin
      rd_addr = i_ff;
      if (state_ff == S_CCAP) rd_addr = '0;
      else if (state_ff == S_SEL) rd_addr = j_ff + IW'(1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:  if (req_fire && req.last_joint)
                     state_in = (count_ff == '0 && !req.joint_valid) ? S_NONE : S_CRD;
         S_CRD:   state_in = S_CCAP;
         S_CCAP:  state_in = S_SEL;
         S_SEL:   if (scan_end) begin
                     if (!found)                          state_in = S_CRD;
                     else if (src_ff == rmb_pkg::SRC_Z)   state_in = phase2_ff ? S_OUT : S_DA;
                     else if (src_ff == rmb_pkg::SRC_D)   state_in = S_LIM;
                     else                                 state_in = S_CRD;
                  end
         S_DA:    state_in = S_DM;
         S_DM:    if (ax_ff == 2'd2)
                     state_in = (i_ff == last_idx) ? S_CRD : S_DA;
         S_LIM:   state_in = S_KEEP;
         S_KEEP:  state_in = S_KRD;
         S_KRD:   if (i_ff == last_idx)
                     state_in = (kcount_fin == '0) ? S_NONE : S_CRD;
                  else
                     state_in = S_KEEP;
         S_OUT:   if (rsp_free) state_in = S_LOAD;
         S_NONE:  if (rsp_free) state_in = S_LOAD;
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         factor_ff <= rmb_pkg::FactorReset;
         count_ff <= '0;
         kept_ff <= '0;
         rsp_valid_ff <= 1'b0;
         phase2_ff <= 1'b0;
         src_ff <= rmb_pkg::SRC_X;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         if (csr_we) factor_ff <= csr_wdata;
         if ((state_ff == S_OUT || state_ff == S_NONE) && rsp_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_fire)
            rsp_valid_ff <= 1'b0;
         state_ff <= state_in;
         unique case (state_ff)
            S_LOAD: begin
               if (req_fire && req.joint_valid && count_ff < CW'(MAX_POINTS))
                  count_ff <= count_ff + CW'(1);
               i_ff <= '0;
               j_ff <= '0;
               src_ff <= rmb_pkg::SRC_X;
               phase2_ff <= 1'b0;
            end
            S_CRD: ;
            S_CCAP: begin
               // candidate value arrives; start inner scan
               vi_ff <= rv;
               rank_ff <= '0;
               j_ff <= '0;
            end
            S_SEL: begin
               // rd data is element j; address of j+1 already out
               if (jsel && below) rank_ff <= rank_ff + CW'(1);
               if (!scan_end) begin
                  j_ff <= j_ff + IW'(1);
               end else if (found) begin
                  // store result; after X and Y move to the next source
                  unique case (src_ff)
                     rmb_pkg::SRC_X: mx_ff <= COORD_BITS'(vi_ff);
                     rmb_pkg::SRC_Y: my_ff <= COORD_BITS'(vi_ff);
                     rmb_pkg::SRC_Z: mz_ff <= COORD_BITS'(vi_ff);
                     default:        md_ff <= DW'(vi_ff);
                  endcase
                  i_ff <= '0;
                  if (src_ff == rmb_pkg::SRC_X || src_ff == rmb_pkg::SRC_Y)
                     src_ff <= rmb_pkg::src_type'(src_ff + 2'd1);
               end else begin
                  i_ff <= i_ff + IW'(1);
               end
            end
            S_DA: begin
               ax_ff <= 2'd0;
               dacc_ff <= '0;
            end
            S_DM: begin
               dacc_ff <= dacc_ff + sq;
               ax_ff <= ax_ff + 2'd1;
               if (ax_ff == 2'd2) begin
                  if (i_ff == last_idx) begin
                     src_ff <= rmb_pkg::SRC_D;
                     i_ff <= '0;
                  end else begin
                     i_ff <= i_ff + IW'(1);
                  end
               end
            end
            S_LIM: begin
               lim_ff <= md_ff * factor_ff;
               kept_ff <= '0;
               kcount_ff <= '0;
               i_ff <= '0;
            end
            S_KEEP: ;
            S_KRD: begin
               if (keep_now) kept_ff[i_ff] <= 1'b1;
               kcount_ff <= kcount_fin;
               if (i_ff == last_idx) begin
                  i_ff <= '0;
                  src_ff <= rmb_pkg::SRC_X;
                  phase2_ff <= 1'b1;
               end else begin
                  i_ff <= i_ff + IW'(1);
               end
            end
            S_OUT: begin
               if (rsp_free) begin
                  ox_ff <= mx_ff;
                  oy_ff <= my_ff;
                  oz_ff <= mz_ff;
                  onv_ff <= 1'b0;
                  count_ff <= '0;
                  kept_ff <= '0;
               end
            end
            S_NONE: begin
               if (rsp_free) begin
                  ox_ff <= '0;
                  oy_ff <= '0;
                  oz_ff <= '0;
                  onv_ff <= 1'b1;
                  count_ff <= '0;
                  kept_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   `RMB_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_POINTS), "count beyond store")
   `RMB_ASSERT(a_no_accept_busy, clock, reset, (state_ff != S_LOAD) |-> !req.ready, "ready while busy")
   `RMB_ASSERT(a_out_after, clock, reset, (state_ff == S_OUT) |=> rsp_valid_ff, "result not shown")
   `RMB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_LOAD && !rsp_valid_ff), "reset state")
endmodule
